// ===== rtl/u16pos_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the UTF-16 position locator.
// No dependencies; every other file in rtl/ depends on this package.
package u16pos_pkg;

    localparam int LINE_BITS       = 24;
    localparam int COLUMN_BITS     = 24;
    localparam int OFFSET_BITS     = 32;
    localparam int OUT_OFFSET_BITS = 32;
    localparam int CP_BITS         = 21;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 24;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [CP_BITS-1:0]     BMP_MAX    = 21'h00FFFF;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    typedef enum logic [2:0] {
        ST_FOUND  = 3'd0,
        ST_LINE   = 3'd1,
        ST_LEAD   = 3'd2,
        ST_CONT   = 3'd3,
        ST_TRUNC  = 3'd4,
        ST_SPLIT  = 3'd5,
        ST_COLUMN = 3'd6
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TARGET_LINE   = 1'b0,
        CFG_TARGET_COLUMN = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                   in_line_search;
        logic [LINE_BITS-1:0]   lines_seen;
        logic [OFFSET_BITS-1:0] offset_count;
        logic [COLUMN_BITS-1:0] units_consumed;
        logic [1:0]             sequence_left;
        logic [CP_BITS-1:0]     partial_code_point;
        logic                   continuation_fault;
        logic                   answered;
    } state_t;

    typedef struct packed {
        logic [OUT_OFFSET_BITS-1:0] byte_offset;
        status_t                    status;
    } result_t;

    // Query state at the start of a text.
    function automatic state_t query_start(logic line_nonzero);
        state_t s;
        s                    = '0;
        s.in_line_search     = line_nonzero;
        return s;
    endfunction

endpackage

// ===== rtl/u16pos_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: text bytes, results and register writes.
// Depends on u16pos_pkg.
interface u16pos_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output has_byte, output end_of_text,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input end_of_text,
                    output ready);
endinterface

interface u16pos_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [u16pos_pkg::OUT_OFFSET_BITS-1:0] byte_offset;
    logic [2:0]                           status;

    modport source (output valid, output byte_offset, output status, input ready);
    modport sink   (input valid, input byte_offset, input status, output ready);
endinterface

interface u16pos_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [u16pos_pkg::CFG_INDEX_BITS-1:0] index;
    logic [u16pos_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/u16pos_step.sv =====
`timescale 1ns / 1ps
// Per-byte update: line count, UTF-8 decode, UTF-16 column match, end handling.
// Purely combinational; depends on u16pos_pkg.
module u16pos_step (
    input  u16pos_pkg::state_t                        state_cur,
    input  logic [7:0]                                data_byte,
    input  logic                                      has_byte,
    input  logic                                      end_of_text,
    input  logic [u16pos_pkg::LINE_BITS-1:0]          target_line,
    input  logic [u16pos_pkg::COLUMN_BITS-1:0]        target_column,
    output u16pos_pkg::state_t                        state_next,
    output logic                                      result_valid,
    output u16pos_pkg::result_t                       result
);

    u16pos_pkg::state_t                      s;
    logic [u16pos_pkg::OFFSET_BITS-1:0]      here;
    logic [1:0]                              cp_units;
    logic [u16pos_pkg::COLUMN_BITS:0]        units_sum;
    logic [u16pos_pkg::COLUMN_BITS:0]        column_ext;
    logic                                    emit;
    u16pos_pkg::status_t                     emit_status;
    logic [u16pos_pkg::OFFSET_BITS-1:0]      emit_offset;

    always_comb
    begin
        s           = state_cur;
        here        = state_cur.offset_count;
        emit        = 1'b0;
        emit_status = u16pos_pkg::ST_FOUND;
        emit_offset = '0;
        cp_units    = 2'd1;
        column_ext  = (u16pos_pkg::COLUMN_BITS + 1)'(target_column);
        units_sum   = (u16pos_pkg::COLUMN_BITS + 1)'(state_cur.units_consumed) + 1'b1;

        if (has_byte && !state_cur.answered)
        begin
            if (state_cur.offset_count != u16pos_pkg::OFFSET_MAX)
            begin
                s.offset_count = state_cur.offset_count + 1'b1;
            end

            if (state_cur.in_line_search)
            begin
                if (data_byte == u16pos_pkg::CHAR_LF)
                begin
                    s.lines_seen = state_cur.lines_seen + 1'b1;
                    if (s.lines_seen >= target_line)
                    begin
                        s.in_line_search = 1'b0;
                    end
                end
            end
            else if (state_cur.sequence_left != 2'd0)
            begin
                if ((data_byte & u16pos_pkg::CONT_MASK) != u16pos_pkg::CONT_TAG)
                begin
                    s.continuation_fault = 1'b1;
                end
                s.partial_code_point = {state_cur.partial_code_point[u16pos_pkg::CP_BITS-7:0],
                                        data_byte[5:0]};
                s.sequence_left      = state_cur.sequence_left - 2'd1;
                if (s.sequence_left == 2'd0)
                begin
                    cp_units  = (s.partial_code_point > u16pos_pkg::BMP_MAX) ? 2'd2 : 2'd1;
                    units_sum = (u16pos_pkg::COLUMN_BITS + 1)'(state_cur.units_consumed)
                              + (u16pos_pkg::COLUMN_BITS + 1)'(cp_units);
                    if (s.continuation_fault)
                    begin
                        emit        = 1'b1;
                        emit_status = u16pos_pkg::ST_CONT;
                    end
                    else if (units_sum > column_ext)
                    begin
                        emit        = 1'b1;
                        emit_status = u16pos_pkg::ST_SPLIT;
                    end
                    else
                    begin
                        s.units_consumed = units_sum[u16pos_pkg::COLUMN_BITS-1:0];
                    end
                end
            end
            else if (data_byte == u16pos_pkg::CHAR_LF || data_byte == u16pos_pkg::CHAR_CR)
            begin
                emit = 1'b1;
                if (state_cur.units_consumed == target_column)
                begin
                    emit_status = u16pos_pkg::ST_FOUND;
                    emit_offset = here;
                end
                else
                begin
                    emit_status = u16pos_pkg::ST_COLUMN;
                end
            end
            else if (state_cur.units_consumed == target_column)
            begin
                emit        = 1'b1;
                emit_status = u16pos_pkg::ST_FOUND;
                emit_offset = here;
            end
            else if (!data_byte[7])
            begin
                if (units_sum > column_ext)
                begin
                    emit        = 1'b1;
                    emit_status = u16pos_pkg::ST_SPLIT;
                end
                else
                begin
                    s.units_consumed = units_sum[u16pos_pkg::COLUMN_BITS-1:0];
                end
            end
            else if (data_byte inside {[8'hC0:8'hDF]})
            begin
                s.sequence_left      = 2'd1;
                s.partial_code_point = u16pos_pkg::CP_BITS'(data_byte[4:0]);
                s.continuation_fault = 1'b0;
            end
            else if (data_byte inside {[8'hE0:8'hEF]})
            begin
                s.sequence_left      = 2'd2;
                s.partial_code_point = u16pos_pkg::CP_BITS'(data_byte[3:0]);
                s.continuation_fault = 1'b0;
            end
            else if (data_byte inside {[8'hF0:8'hF7]})
            begin
                s.sequence_left      = 2'd3;
                s.partial_code_point = u16pos_pkg::CP_BITS'(data_byte[2:0]);
                s.continuation_fault = 1'b0;
            end
            else
            begin
                emit        = 1'b1;
                emit_status = u16pos_pkg::ST_LEAD;
            end

            if (emit)
            begin
                s.answered = 1'b1;
            end
        end

        if (end_of_text)
        begin
            if (!emit && !state_cur.answered)
            begin
                emit = 1'b1;
                if (s.in_line_search)
                begin
                    emit_status = u16pos_pkg::ST_LINE;
                end
                else if (s.sequence_left != 2'd0)
                begin
                    emit_status = u16pos_pkg::ST_TRUNC;
                end
                else if (s.units_consumed == target_column)
                begin
                    emit_status = u16pos_pkg::ST_FOUND;
                    emit_offset = s.offset_count;
                end
                else
                begin
                    emit_status = u16pos_pkg::ST_COLUMN;
                end
            end
            s = u16pos_pkg::query_start(target_line != '0);
        end

        state_next         = s;
        result_valid       = emit;
        result.byte_offset = u16pos_pkg::OUT_OFFSET_BITS'(emit_offset);
        result.status      = emit_status;
    end

endmodule

// ===== rtl/utf16_position_to_byte_offset.sv =====
`timescale 1ns / 1ps
// Top level: input register, per-byte step, result register, target registers.
// Depends on u16pos_pkg, u16pos_if.sv and u16pos_step.
//
//   channel  modport  request carries                      accepted when
//   text     sink     data_byte, has_byte, end_of_text     text.valid && text.ready
//   result   source   byte_offset, status                  result.valid && result.ready
//   cfg      sink     index (0 line, 1 column), data       cfg.valid (ready held high)
//
// One byte per cycle sustained unless the result stalls; a byte's result is
// registered behind the input register. The single decode/compare step sets
// the rate. rst_n clears the query state, both targets and both valid flags.
// A stalled result holds the step stage; text.ready stays high while the
// input register is empty or the step stage can advance.
module utf16_position_to_byte_offset (
    input  logic        clk,
    input  logic        rst_n,
    u16pos_text_if.sink     text,
    u16pos_result_if.source result,
    u16pos_cfg_if.sink      cfg
);

    logic                                   in_valid_reg;
    logic [7:0]                             in_byte_reg;
    logic                                   in_has_reg;
    logic                                   in_end_reg;

    logic                                   out_valid_reg;
    u16pos_pkg::result_t                    out_reg;

    u16pos_pkg::state_t                     state_reg;
    u16pos_pkg::state_t                     state_next;
    u16pos_pkg::state_t                     step_state;
    logic [u16pos_pkg::LINE_BITS-1:0]       target_line_reg;
    logic [u16pos_pkg::LINE_BITS-1:0]       target_line_next;
    logic [u16pos_pkg::COLUMN_BITS-1:0]     target_column_reg;
    logic [u16pos_pkg::COLUMN_BITS-1:0]     target_column_next;

    logic                                   advance;
    logic                                   process;
    logic                                   text_take;
    logic                                   cfg_take;
    logic                                   step_valid;
    u16pos_pkg::result_t                    step_result;

    assign advance    = !out_valid_reg || result.ready;
    assign process    = in_valid_reg && advance;
    assign text.ready = !in_valid_reg || advance;
    assign text_take  = text.valid && text.ready;
    assign cfg.ready  = 1'b1;
    assign cfg_take   = cfg.valid;

    assign result.valid       = out_valid_reg;
    assign result.byte_offset = out_reg.byte_offset;
    assign result.status      = out_reg.status;

    u16pos_step u_step (
        .state_cur     (state_reg),
        .data_byte     (in_byte_reg),
        .has_byte      (in_has_reg),
        .end_of_text   (in_end_reg),
        .target_line   (target_line_reg),
        .target_column (target_column_reg),
        .state_next    (step_state),
        .result_valid  (step_valid),
        .result        (step_result)
    );

    always_comb
    begin
        state_next         = state_reg;
        target_line_next   = target_line_reg;
        target_column_next = target_column_reg;
        if (cfg_take)
        begin
            case (u16pos_pkg::cfg_index_t'(cfg.index))
                u16pos_pkg::CFG_TARGET_LINE:
                begin
                    target_line_next          = cfg.data;
                    state_next.in_line_search = state_reg.lines_seen < cfg.data;
                    if (state_reg.lines_seen < cfg.data)
                    begin
                        state_next.units_consumed     = '0;
                        state_next.sequence_left      = '0;
                        state_next.partial_code_point = '0;
                        state_next.continuation_fault = 1'b0;
                    end
                end
                u16pos_pkg::CFG_TARGET_COLUMN:
                begin
                    target_column_next = cfg.data;
                end
                default:
                begin
                    target_column_next = target_column_reg;
                end
            endcase
        end
        else if (process)
        begin
            state_next = step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg         <= u16pos_pkg::query_start(1'b0);
            target_line_reg   <= '0;
            target_column_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            target_line_reg   <= target_line_next;
            target_column_reg <= target_column_next;
            if (text_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= process && step_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            in_byte_reg <= text.data_byte;
            in_has_reg  <= text.has_byte;
            in_end_reg  <= text.end_of_text;
        end
        if (process && step_valid)
        begin
            out_reg <= step_result;
        end
    end

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (in_valid_reg && out_valid_reg && !result.ready))
        else $error("text stalled without a blocked result");

    a_answered_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (process && step_valid && !in_end_reg && !cfg_take) |=> state_reg.answered)
        else $error("result issued but query not marked answered");

    a_offset_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (process && !in_end_reg && !cfg_take)
        |=> (state_reg.offset_count >= $past(state_reg.offset_count)))
        else $error("offset counter moved backward within a text");

    a_no_sequence_in_line_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.sequence_left != 2'd0) |-> !state_reg.in_line_search)
        else $error("open UTF-8 sequence during line search");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for utf16_position_to_byte_offset: streams UTF-8 queries,
// predicts each located offset or error status and checks every result.
// Depends on u16pos_pkg, the channel interfaces in u16pos_if.sv and the RTL top.
module tb_top;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct {
        bit                                   is_write;
        u16pos_pkg::cfg_index_t               reg_sel;
        logic [u16pos_pkg::CFG_DATA_BITS-1:0] value;
        logic [7:0]                           data_byte;
        bit                                   has_byte;
        bit                                   end_of_text;
    } request_t;

    logic clk = 1'b0;
    logic rst_n;

    u16pos_text_if   text_ch ();
    u16pos_result_if result_ch ();
    u16pos_cfg_if    cfg_ch ();

    utf16_position_to_byte_offset dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    request_t            text_requests [$];
    u16pos_pkg::result_t position_answers [$];
    int                  planned_items;
    int                  accepted_items;
    int                  quiet_cycles = SETTLE_CYCLES;
    int                  mismatches;
    int                  cycle_count;

    wire steady = (accepted_items >= 900) && (accepted_items < 1300);

    // Locator state
    logic [u16pos_pkg::LINE_BITS-1:0]   line_goal;
    logic [u16pos_pkg::COLUMN_BITS-1:0] column_goal;
    bit                                 seeking_line;
    logic [u16pos_pkg::LINE_BITS-1:0]   lines_passed;
    logic [u16pos_pkg::OFFSET_BITS-1:0] bytes_seen;
    logic [u16pos_pkg::COLUMN_BITS-1:0] units_done;
    logic [1:0]                         seq_left;
    logic [u16pos_pkg::CP_BITS-1:0]     cp_acc;
    bit                                 cont_bad;
    bit                                 replied;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void restart_query();
        seeking_line = (line_goal != '0);
        lines_passed = '0;
        bytes_seen   = '0;
        units_done   = '0;
        seq_left     = '0;
        cp_acc       = '0;
        cont_bad     = 1'b0;
        replied      = 1'b0;
    endfunction

    function automatic void post_answer(logic [u16pos_pkg::OFFSET_BITS-1:0] off,
                                        u16pos_pkg::status_t st);
        u16pos_pkg::result_t a;
        a.byte_offset = (st == u16pos_pkg::ST_FOUND)
                        ? off[u16pos_pkg::OUT_OFFSET_BITS-1:0] : '0;
        a.status      = st;
        position_answers.push_back(a);
        replied = 1'b1;
    endfunction

    function automatic void locate_byte(logic [7:0] b);
        logic [u16pos_pkg::OFFSET_BITS-1:0] here;
        logic [u16pos_pkg::COLUMN_BITS:0]   wide;
        here = bytes_seen;
        if (bytes_seen != u16pos_pkg::OFFSET_MAX)
            bytes_seen = bytes_seen + 1'b1;
        if (seeking_line)
        begin
            if (b == u16pos_pkg::CHAR_LF)
            begin
                lines_passed = lines_passed + 1'b1;
                if (lines_passed >= line_goal)
                    seeking_line = 1'b0;
            end
        end
        else if (seq_left != 2'd0)
        begin
            if ((b & u16pos_pkg::CONT_MASK) != u16pos_pkg::CONT_TAG)
                cont_bad = 1'b1;
            cp_acc   = {cp_acc[u16pos_pkg::CP_BITS-7:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                wide = {1'b0, units_done}
                     + ((cp_acc > u16pos_pkg::BMP_MAX)
                        ? (u16pos_pkg::COLUMN_BITS + 1)'(2)
                        : (u16pos_pkg::COLUMN_BITS + 1)'(1));
                if (cont_bad)
                    post_answer('0, u16pos_pkg::ST_CONT);
                else if (wide > {1'b0, column_goal})
                    post_answer('0, u16pos_pkg::ST_SPLIT);
                else
                    units_done = wide[u16pos_pkg::COLUMN_BITS-1:0];
            end
        end
        else if (b == u16pos_pkg::CHAR_LF || b == u16pos_pkg::CHAR_CR)
        begin
            if (units_done == column_goal)
                post_answer(here, u16pos_pkg::ST_FOUND);
            else
                post_answer('0, u16pos_pkg::ST_COLUMN);
        end
        else if (units_done == column_goal)
        begin
            post_answer(here, u16pos_pkg::ST_FOUND);
        end
        else if (!b[7])
        begin
            wide = {1'b0, units_done} + 1'b1;
            if (wide > {1'b0, column_goal})
                post_answer('0, u16pos_pkg::ST_SPLIT);
            else
                units_done = wide[u16pos_pkg::COLUMN_BITS-1:0];
        end
        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
        begin
            if (b[7:5] == 3'b110)
            begin
                seq_left = 2'd1;
                cp_acc   = u16pos_pkg::CP_BITS'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110)
            begin
                seq_left = 2'd2;
                cp_acc   = u16pos_pkg::CP_BITS'(b[3:0]);
            end
            else
            begin
                seq_left = 2'd3;
                cp_acc   = u16pos_pkg::CP_BITS'(b[2:0]);
            end
            cont_bad = 1'b0;
        end
        else
        begin
            post_answer('0, u16pos_pkg::ST_LEAD);
        end
    endfunction

    function automatic void close_text();
        if (seeking_line)
            post_answer('0, u16pos_pkg::ST_LINE);
        else if (seq_left != 2'd0)
            post_answer('0, u16pos_pkg::ST_TRUNC);
        else if (units_done == column_goal)
            post_answer(bytes_seen, u16pos_pkg::ST_FOUND);
        else
            post_answer('0, u16pos_pkg::ST_COLUMN);
    endfunction

    function automatic void take_text(logic [7:0] b, bit has, bit last);
        if (has && !replied)
            locate_byte(b);
        if (last)
        begin
            if (!replied)
                close_text();
            restart_query();
        end
    endfunction

    function automatic void write_target(u16pos_pkg::cfg_index_t sel,
                                         logic [u16pos_pkg::CFG_DATA_BITS-1:0] v);
        if (sel == u16pos_pkg::CFG_TARGET_LINE)
        begin
            line_goal    = v;
            seeking_line = (lines_passed < line_goal);
            if (seeking_line)
            begin
                units_done = '0;
                seq_left   = '0;
                cp_acc     = '0;
                cont_bad   = 1'b0;
            end
        end
        else
        begin
            column_goal = v;
        end
    endfunction

    task automatic push_byte(logic [7:0] b, bit last = 1'b0);
        request_t r;
        r = '{is_write: 1'b0, reg_sel: u16pos_pkg::CFG_TARGET_LINE, value: '0,
              data_byte: b, has_byte: 1'b1, end_of_text: last};
        text_requests.push_back(r);
        planned_items++;
    endtask

    task automatic push_end();
        request_t r;
        r = '{is_write: 1'b0, reg_sel: u16pos_pkg::CFG_TARGET_LINE, value: '0,
              data_byte: 8'($urandom), has_byte: 1'b0, end_of_text: 1'b1};
        text_requests.push_back(r);
        planned_items++;
    endtask

    task automatic push_blank();
        request_t r;
        r = '{is_write: 1'b0, reg_sel: u16pos_pkg::CFG_TARGET_LINE, value: '0,
              data_byte: 8'($urandom), has_byte: 1'b0, end_of_text: 1'b0};
        text_requests.push_back(r);
    endtask

    task automatic push_write(u16pos_pkg::cfg_index_t sel,
                              logic [u16pos_pkg::CFG_DATA_BITS-1:0] v);
        request_t r;
        r = '{is_write: 1'b1, reg_sel: sel, value: v,
              data_byte: '0, has_byte: 1'b0, end_of_text: 1'b0};
        text_requests.push_back(r);
    endtask

    task automatic push_code_point(int w, bit corrupt);
        logic [u16pos_pkg::CP_BITS-1:0] cp;
        logic [7:0]                     seq [4];
        int                             n;
        case (w)
            1:
            begin
                cp = u16pos_pkg::CP_BITS'($urandom_range(0, 127));
                if (cp == u16pos_pkg::CHAR_LF || cp == u16pos_pkg::CHAR_CR)
                    cp = 21'h7F;
                seq[0] = cp[7:0];
                n = 1;
            end
            2:
            begin
                cp = u16pos_pkg::CP_BITS'($urandom_range(21'h80, 21'h7FF));
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
                n = 2;
            end
            3:
            begin
                cp = u16pos_pkg::CP_BITS'($urandom_range(21'h800, 21'hFFFF));
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
                n = 3;
            end
            default:
            begin
                cp = u16pos_pkg::CP_BITS'($urandom_range(21'h10000, 21'h10FFFF));
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
                n = 4;
            end
        endcase
        if (corrupt)
        begin
            case ($urandom_range(0, 2))
                0: if (n > 1) n--;
                1: seq[$urandom_range(0, n - 1)] = 8'($urandom);
                default: seq[0] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                        : 8'($urandom_range(8'hF8, 8'hFF));
            endcase
        end
        for (int i = 0; i < n; i++)
            push_byte(seq[i]);
    endtask

    task automatic add_query(logic [u16pos_pkg::LINE_BITS-1:0] line_v,
                             logic [u16pos_pkg::COLUMN_BITS-1:0] col_v);
        int         n_lines;
        int         goal_units;
        int         units;
        int         w;
        int         last;
        logic [7:0] filler;
        if ($urandom_range(0, 19) == 0)
            push_blank();
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 12))
                push_byte(($urandom_range(0, 5) == 0) ? u16pos_pkg::CHAR_LF : 8'($urandom));
        end
        else
        begin
            n_lines = (line_v <= 4) ? int'(line_v) : $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0)
                n_lines = $urandom_range(0, 4);
            repeat (n_lines)
            begin
                repeat ($urandom_range(0, 3))
                begin
                    filler = 8'($urandom);
                    if (filler == u16pos_pkg::CHAR_LF)
                        filler = u16pos_pkg::CHAR_CR;
                    push_byte(filler);
                end
                push_byte(u16pos_pkg::CHAR_LF);
            end
            goal_units = ((col_v <= 12) ? int'(col_v) : $urandom_range(0, 12))
                         + $urandom_range(0, 2);
            units = 0;
            while (units < goal_units)
            begin
                w = $urandom_range(1, 4);
                push_code_point(w, $urandom_range(0, 99) < 8);
                units += (w == 4) ? 2 : 1;
            end
            case ($urandom_range(0, 3))
                0: push_byte(u16pos_pkg::CHAR_CR);
                1: push_byte(u16pos_pkg::CHAR_LF);
                2: repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
                default: ;
            endcase
        end
        last = text_requests.size() - 1;
        if (!text_requests[last].is_write && text_requests[last].has_byte
            && !text_requests[last].end_of_text && $urandom_range(0, 1))
            text_requests[last].end_of_text = 1'b1;
        else
            push_end();
    endtask

    // Request driver
    always @(posedge clk)
    begin
        request_t head;
        logic     give_text;
        logic     give_write;
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                head = text_requests.pop_front();
                take_text(head.data_byte, head.has_byte, head.end_of_text);
                quiet_cycles = 0;
                accepted_items++;
            end
            else if (quiet_cycles < SETTLE_CYCLES)
            begin
                quiet_cycles++;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                head = text_requests.pop_front();
                write_target(head.reg_sel, head.value);
            end
            if (!(text_ch.valid && !text_ch.ready) && !(cfg_ch.valid && !cfg_ch.ready))
            begin
                give_text  = 1'b0;
                give_write = 1'b0;
                if (text_requests.size() != 0)
                begin
                    head = text_requests[0];
                    if (head.is_write)
                        give_write = (quiet_cycles >= SETTLE_CYCLES)
                                     && (position_answers.size() == 0);
                    else
                        give_text = steady || ($urandom_range(0, 99) >= 14);
                    if (give_text)
                    begin
                        text_ch.data_byte   <= head.data_byte;
                        text_ch.has_byte    <= head.has_byte;
                        text_ch.end_of_text <= head.end_of_text;
                    end
                    if (give_write)
                    begin
                        cfg_ch.index <= head.reg_sel;
                        cfg_ch.data  <= head.value;
                    end
                end
                text_ch.valid <= give_text;
                cfg_ch.valid  <= give_write;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        u16pos_pkg::result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (position_answers.size() == 0)
                begin
                    $display("%0t: unexpected result byte_offset %0d status %0d",
                             $time, result_ch.byte_offset, result_ch.status);
                    mismatches++;
                end
                else
                begin
                    want = position_answers.pop_front();
                    if (result_ch.byte_offset !== want.byte_offset)
                    begin
                        $display("%0t: byte_offset expected %0d actual %0d",
                                 $time, want.byte_offset, result_ch.byte_offset);
                        mismatches++;
                    end
                    if (result_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, result_ch.status);
                        mismatches++;
                    end
                end
            end
            result_ch.ready <= steady || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("utf16_position_to_byte_offset test failed");
            $finish;
        end
    end

    initial
    begin
        logic [u16pos_pkg::LINE_BITS-1:0]   line_pick;
        logic [u16pos_pkg::COLUMN_BITS-1:0] col_pick;
        rst_n               = 1'b0;
        text_ch.valid       = 1'b0;
        text_ch.data_byte   = '0;
        text_ch.has_byte    = 1'b0;
        text_ch.end_of_text = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = u16pos_pkg::CFG_TARGET_LINE;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        line_goal           = '0;
        column_goal         = '0;
        restart_query();

        push_end();
        push_blank();
        push_byte(8'h78, 1'b1);
        push_write(u16pos_pkg::CFG_TARGET_COLUMN, 24'd3);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hC3);
        push_byte(u16pos_pkg::CHAR_LF, 1'b1);
        push_byte(8'hE2);
        push_byte(8'h82, 1'b1);
        push_byte(8'hF0);
        push_byte(8'h9F);
        push_byte(8'h98);
        push_byte(8'h80);
        push_byte(8'h61);
        push_byte(u16pos_pkg::CHAR_CR);
        push_byte(8'h71);
        push_end();
        push_write(u16pos_pkg::CFG_TARGET_COLUMN, 24'd1);
        push_byte(8'hF0);
        push_byte(8'h9F);
        push_byte(8'h98);
        push_byte(8'h80, 1'b1);
        push_write(u16pos_pkg::CFG_TARGET_LINE, 24'hFFFFFF);
        push_write(u16pos_pkg::CFG_TARGET_COLUMN, 24'hFFFFFF);
        push_byte(u16pos_pkg::CHAR_LF, 1'b1);
        push_write(u16pos_pkg::CFG_TARGET_LINE, 24'd0);
        push_write(u16pos_pkg::CFG_TARGET_COLUMN, 24'd5);
        push_byte(8'h61);
        push_byte(8'h62);
        push_write(u16pos_pkg::CFG_TARGET_LINE, 24'd2);
        push_write(u16pos_pkg::CFG_TARGET_COLUMN, 24'd1);
        push_byte(u16pos_pkg::CHAR_LF);
        push_byte(u16pos_pkg::CHAR_LF);
        push_byte(8'h78);
        push_byte(u16pos_pkg::CHAR_CR, 1'b1);

        planned_items = 0;
        while (planned_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: line_pick = 24'hFFFFFF;
                1: line_pick = 24'($urandom);
                default: line_pick = 24'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 9))
                0: col_pick = 24'hFFFFFF;
                1: col_pick = 24'($urandom);
                default: col_pick = 24'($urandom_range(0, 10));
            endcase
            if ($urandom_range(0, 1))
            begin
                push_write(u16pos_pkg::CFG_TARGET_LINE, line_pick);
                push_write(u16pos_pkg::CFG_TARGET_COLUMN, col_pick);
            end
            else
            begin
                push_write(u16pos_pkg::CFG_TARGET_COLUMN, col_pick);
                push_write(u16pos_pkg::CFG_TARGET_LINE, line_pick);
            end
            repeat ($urandom_range(2, 6))
                add_query(line_pick, col_pick);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (text_requests.size() != 0 || position_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("utf16_position_to_byte_offset test passed");
        else
            $display("utf16_position_to_byte_offset test failed");
        $finish;
    end

endmodule
